>>> hw/rtl/vwf_pkg.sv
// Shared types, codes and constants for the variable-width glyph blitter.
// Used by the top level vwf_glyph_blitter and by the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package vwf_pkg;

  localparam int GLYPH_COUNT_DEF    = 96;
  localparam int TILE_MEM_BYTES_DEF = 4096;

  localparam int GLYPH_BYTES = 9;
  localparam logic [7:0] CODE_BASE = 8'h20;
  localparam logic [3:0] WIDTH_MAX = 4'd8;
  localparam logic [4:0] SHIFT_TOP = 5'd17;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    FUNC_LOAD_FONT  = 2'd0,
    FUNC_DRAW       = 2'd1,
    FUNC_READ_TILE  = 2'd2,
    FUNC_WRITE_TILE = 2'd3
  } func_t;

  typedef enum logic {
    REG_COLOR_MODE = 1'b0,
    REG_LINE_BASE  = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WIDTH,
    S_ROWS,
    S_RDWAIT,
    S_DONE
  } state_t;

  function automatic logic [7:0] width_mask(input logic [3:0] w);
    logic [7:0] m;
    case (w)
      4'd0:    m = 8'h00;
      4'd1:    m = 8'h01;
      4'd2:    m = 8'h03;
      4'd3:    m = 8'h07;
      4'd4:    m = 8'h0F;
      4'd5:    m = 8'h1F;
      4'd6:    m = 8'h3F;
      4'd7:    m = 8'h7F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/vwf_font_mem.sv
// Single-port font store with a registered read port.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module vwf_font_mem #(
  parameter int DEPTH = 864,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic [7:0]         rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/vwf_tile_mem.sv
// Tile store with one write port and one registered read port.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module vwf_tile_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/vwf_glyph_blitter.sv
// Top level of the glyph blitter: stream ports, configuration, sequencer.
// Depends on vwf_pkg, vwf_font_mem and vwf_tile_mem.
//
// Usage: input transactions arrive on the s_ group; s_tuser selects the
// operation (load font byte, draw glyph, read tile byte, write tile byte).
// Every input transaction yields exactly one output transaction on the m_
// group, in order; m_tuser carries the status flag (1 = out of range).
// The configuration port takes a write whenever cfg_we is high.
// Items are handled one at a time. A load or tile write finishes in the
// decode state, a tile read in the read-wait state after it, and a draw
// goes through decode, a step for the glyph width, then 16 byte
// read-modify-writes streamed through the read and write ports of the tile
// store, which sets the draw rate. The next item is accepted in the cycle
// after the result is registered. A finished result waits in the output
// register while a new item is accepted; if the receiver still stalls when
// the next result is ready, that result is parked and the block holds off
// further input until it moves on. Reset clears control state and the
// configuration registers; the font and tile stores are not cleared and
// must be written before they are read.
`timescale 1ns / 1ps
`default_nettype none

module vwf_glyph_blitter #(
  parameter int GLYPH_COUNT    = vwf_pkg::GLYPH_COUNT_DEF,
  parameter int TILE_MEM_BYTES = vwf_pkg::TILE_MEM_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // char_code[7:0], x_pos[17:8], addr[29:18], data[37:30], zero[39:38]
  input  wire logic [vwf_pkg::IN_DATA_W-1:0]   s_tdata,
  // func[1:0]
  input  wire logic [1:0]                      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // next_x[10:0], read_data[18:11], zero[23:19]
  output logic [vwf_pkg::OUT_DATA_W-1:0]       m_tdata,
  // status[0]
  output logic                                 m_tuser,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [11:0]                     cfg_data
);

  import vwf_pkg::*;

  localparam int FONT_BYTES = GLYPH_COUNT * GLYPH_BYTES;
  localparam int FA = (FONT_BYTES > 1) ? $clog2(FONT_BYTES) : 1;
  localparam int TA = $clog2(TILE_MEM_BYTES);
  localparam int CMP_MIN = 14;
  localparam int CmpW = ($clog2(TILE_MEM_BYTES + 1) > CMP_MIN) ?
                        $clog2(TILE_MEM_BYTES + 1) : CMP_MIN;

  logic        color_mode;
  logic [11:0] line_base;

  state_t state, state_next;

  func_t       item_func;
  logic [7:0]  item_code;
  logic [9:0]  item_x;
  logic [11:0] item_addr;
  logic [7:0]  item_data;

  logic [FA-1:0] fbase;
  logic [TA-1:0] base;
  logic [3:0]    glyph_w;
  logic [4:0]    shamt;
  logic [15:0]   mask;
  logic [4:0]    cnt;
  logic [TA-1:0] pend_addr;
  logic          pend_side;

  logic        out_valid;
  logic [10:0] out_nx;
  logic [7:0]  out_rd;
  logic        out_st;
  logic [10:0] hold_nx;
  logic [7:0]  hold_rd;
  logic        hold_st;

  logic          font_we;
  logic          font_re;
  logic [FA-1:0] font_addr;
  logic [7:0]    font_rdata;
  logic          tile_we;
  logic [TA-1:0] tile_waddr;
  logic [7:0]    tile_wdata;
  logic          tile_re;
  logic [TA-1:0] tile_raddr;
  logic [7:0]    tile_rdata;

  logic          fin;
  logic [10:0]   res_nx;
  logic [7:0]    res_rd;
  logic          res_st;
  logic          slot_free;
  logic          out_load;
  logic          s_accept;

  logic [7:0]    glyph_idx;
  logic          code_ok;
  logic [10:0]   fbase_full;
  logic [12:0]   base_c;
  logic [CmpW-1:0] top_c;
  logic          draw_ok;
  logic          font_addr_ok;
  logic          tile_addr_ok;
  logic [3:0]    wsat;
  logic [4:0]    shamt_c;
  logic [3:0]    op_idx;
  logic [4:0]    row_off;
  logic [5:0]    side_off;
  logic [TA-1:0] op_addr;
  logic [15:0]   bits;
  logic [7:0]    merged;

  assign s_tready  = (state == S_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign slot_free = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_rd, out_nx};
  assign m_tuser  = out_st;

  // Address and range calculations.
  assign glyph_idx    = item_code - CODE_BASE;
  assign code_ok      = (item_code >= CODE_BASE) && ({1'b0, glyph_idx} < 9'(GLYPH_COUNT));
  assign fbase_full   = {glyph_idx, 3'b000} + {3'b000, glyph_idx};
  assign base_c       = {1'b0, line_base} +
                        (color_mode ? {1'b0, item_x[9:3], 5'd0} : {2'b00, item_x[9:3], 4'd0});
  assign top_c        = CmpW'(base_c) + (color_mode ? CmpW'(60) : CmpW'(30));
  assign draw_ok      = code_ok && (top_c < CmpW'(TILE_MEM_BYTES));
  assign font_addr_ok = (item_addr < 12'(FONT_BYTES));
  assign tile_addr_ok = (CmpW'(item_addr) < CmpW'(TILE_MEM_BYTES));

  assign wsat    = (font_rdata > 8'(WIDTH_MAX)) ? WIDTH_MAX : font_rdata[3:0];
  assign shamt_c = SHIFT_TOP - {1'b0, wsat} - {2'b00, item_x[2:0]};

  assign op_idx   = (state == S_WIDTH) ? 4'd0 : cnt[3:0];
  assign row_off  = color_mode ? {op_idx[3:1], 2'b00} : {1'b0, op_idx[3:1], 1'b0};
  assign side_off = op_idx[0] ? (color_mode ? 6'd32 : 6'd16) : 6'd0;
  assign op_addr  = base + TA'(row_off) + TA'(side_off);

  assign bits   = {8'd0, font_rdata} << shamt;
  assign merged = pend_side ? ((tile_rdata & mask[7:0]) | bits[7:0]) :
                              ((tile_rdata & mask[15:8]) | bits[15:8]);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (item_func == FUNC_DRAW && draw_ok) begin
          state_next = S_WIDTH;
        end else if (item_func == FUNC_READ_TILE && tile_addr_ok) begin
          state_next = S_RDWAIT;
        end else begin
          state_next = slot_free ? S_IDLE : S_DONE;
        end
      end
      S_WIDTH: begin
        state_next = S_ROWS;
      end
      S_ROWS: begin
        if (cnt[4]) begin
          state_next = slot_free ? S_IDLE : S_DONE;
        end
      end
      S_RDWAIT: begin
        state_next = slot_free ? S_IDLE : S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    font_we    = 1'b0;
    font_re    = 1'b0;
    font_addr  = FA'(item_addr);
    tile_we    = 1'b0;
    tile_waddr = TA'(item_addr);
    tile_wdata = item_data;
    tile_re    = 1'b0;
    tile_raddr = TA'(item_addr);
    fin        = 1'b0;
    res_nx     = 11'd0;
    res_rd     = 8'd0;
    res_st     = 1'b0;
    case (state)
      S_DECODE: begin
        case (item_func)
          FUNC_LOAD_FONT: begin
            font_we = font_addr_ok;
            fin     = 1'b1;
            res_st  = !font_addr_ok;
          end
          FUNC_DRAW: begin
            font_re   = draw_ok;
            font_addr = FA'(fbase_full);
            fin       = !draw_ok;
            res_nx    = {1'b0, item_x};
            res_st    = 1'b1;
          end
          FUNC_READ_TILE: begin
            tile_re = tile_addr_ok;
            fin     = !tile_addr_ok;
            res_st  = 1'b1;
          end
          default: begin
            tile_we = tile_addr_ok;
            fin     = 1'b1;
            res_st  = !tile_addr_ok;
          end
        endcase
      end
      S_WIDTH: begin
        font_re    = 1'b1;
        font_addr  = fbase + FA'(1);
        tile_re    = 1'b1;
        tile_raddr = op_addr;
      end
      S_ROWS: begin
        tile_we    = 1'b1;
        tile_waddr = pend_addr;
        tile_wdata = merged;
        tile_re    = !cnt[4];
        tile_raddr = op_addr;
        font_re    = !cnt[4] && !cnt[0];
        font_addr  = fbase + FA'(cnt[3:1]) + FA'(1);
        fin        = cnt[4];
        res_nx     = {1'b0, item_x} + {7'd0, glyph_w};
      end
      S_RDWAIT: begin
        fin    = 1'b1;
        res_rd = tile_rdata;
      end
      default: begin
      end
    endcase
  end

  assign out_load = slot_free && (fin || state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      cnt        <= 5'd0;
      color_mode <= 1'b0;
      line_base  <= 12'd0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_COLOR_MODE: color_mode <= cfg_data[0];
          REG_LINE_BASE:  line_base  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (state == S_WIDTH) begin
        cnt <= 5'd1;
      end else if (state == S_ROWS) begin
        cnt <= cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      item_func <= func_t'(s_tuser);
      item_code <= s_tdata[7:0];
      item_x    <= s_tdata[17:8];
      item_addr <= s_tdata[29:18];
      item_data <= s_tdata[37:30];
    end
    if (state == S_DECODE) begin
      fbase <= FA'(fbase_full);
      base  <= TA'(base_c);
    end
    if (state == S_WIDTH) begin
      glyph_w <= wsat;
      shamt   <= shamt_c;
      mask    <= ~({8'd0, width_mask(wsat)} << shamt_c);
    end
    if (tile_re && (state == S_WIDTH || state == S_ROWS)) begin
      pend_addr <= tile_raddr;
      pend_side <= op_idx[0];
    end
    if (fin) begin
      hold_nx <= res_nx;
      hold_rd <= res_rd;
      hold_st <= res_st;
    end
    if (out_load) begin
      out_nx <= fin ? res_nx : hold_nx;
      out_rd <= fin ? res_rd : hold_rd;
      out_st <= fin ? res_st : hold_st;
    end
  end

  vwf_font_mem #(
    .DEPTH (FONT_BYTES),
    .AW    (FA)
  ) u_font_mem (
    .clk   (clk),
    .we    (font_we),
    .re    (font_re),
    .addr  (font_addr),
    .wdata (item_data),
    .rdata (font_rdata)
  );

  vwf_tile_mem #(
    .DEPTH (TILE_MEM_BYTES),
    .AW    (TA)
  ) u_tile_mem (
    .clk   (clk),
    .we    (tile_we),
    .waddr (tile_waddr),
    .wdata (tile_wdata),
    .re    (tile_re),
    .raddr (tile_raddr),
    .rdata (tile_rdata)
  );

`ifndef SYNTHESIS
  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    !(tile_we && tile_re && tile_waddr == tile_raddr))
    else $error("tile store read and written at the same entry");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over an unaccepted transaction");

  a_rows_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROWS) |-> (cnt <= 5'd16 && cnt != 5'd0))
    else $error("row sequencer count out of range");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> m_tvalid)
    else $error("parked result without a pending output transaction");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    fin |=> (state == S_IDLE || state == S_DONE))
    else $error("sequencer continued after finishing a transaction");
`endif

endmodule

`default_nettype wire

>>> tb/vwf_glyph_blitter_checker.sv
// Scoreboard for the glyph blitter: watches the input, output and configuration ports,
// keeps shadow copies of the font and tile stores, and checks every output transaction.
// Depends on vwf_pkg for the operation and register codes and the store sizes.
`timescale 1ns / 1ps

module vwf_glyph_blitter_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  input  wire logic                          s_tready,
  input  wire logic [vwf_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic [1:0]                    s_tuser,
  input  wire logic                          m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic [vwf_pkg::OUT_DATA_W-1:0] m_tdata,
  input  wire logic                          m_tuser,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [11:0]                   cfg_data,
  output int                                 mismatches,
  output int                                 outstanding
);

  localparam int FONT_BYTES = vwf_pkg::GLYPH_COUNT_DEF * vwf_pkg::GLYPH_BYTES;
  localparam int TILE_BYTES = vwf_pkg::TILE_MEM_BYTES_DEF;

  typedef struct packed {
    logic [10:0] next_x;
    logic [7:0]  read_data;
    logic        status;
  } blit_result_t;

  logic [7:0]   font_shadow [FONT_BYTES];
  logic [7:0]   tile_shadow [TILE_BYTES];
  logic         color_mode;
  logic [11:0]  line_base;
  blit_result_t expected_q [$];
  int           err_cnt;

  function automatic blit_result_t blit_glyph(input logic [7:0] code, input logic [9:0] x);
    blit_result_t r;
    int unsigned  glyph, fbase, w, shift, stride, tsize, base, a0, a1, row;
    logic [31:0]  keep, bits;
    r = '0;
    r.next_x = {1'b0, x};
    r.status = 1'b1;
    if (code < vwf_pkg::CODE_BASE) return r;
    glyph = code - vwf_pkg::CODE_BASE;
    if (glyph >= vwf_pkg::GLYPH_COUNT_DEF) return r;
    fbase = glyph * vwf_pkg::GLYPH_BYTES;
    w = font_shadow[fbase];
    if (w > vwf_pkg::WIDTH_MAX) w = vwf_pkg::WIDTH_MAX;
    shift = vwf_pkg::SHIFT_TOP - w - x[2:0];
    stride = color_mode ? 4 : 2;
    tsize = color_mode ? 32 : 16;
    base = line_base + x[9:3] * tsize;
    if (base + 7 * stride + tsize >= TILE_BYTES) return r;
    keep = ~(((32'd1 << w) - 32'd1) << shift);
    for (row = 0; row < 8; row++) begin
      bits = {24'h0, font_shadow[fbase + 1 + row]} << shift;
      a0 = base + row * stride;
      a1 = a0 + tsize;
      tile_shadow[a0] = (tile_shadow[a0] & keep[15:8]) | bits[15:8];
      tile_shadow[a1] = (tile_shadow[a1] & keep[7:0]) | bits[7:0];
    end
    r.next_x = x + w;
    r.status = 1'b0;
    return r;
  endfunction

  function automatic blit_result_t apply_item(input vwf_pkg::func_t op, input logic [7:0] code,
      input logic [9:0] x, input logic [11:0] addr, input logic [7:0] data);
    blit_result_t r;
    r = '0;
    case (op)
      vwf_pkg::FUNC_LOAD_FONT: begin
        if (addr < FONT_BYTES) font_shadow[addr] = data;
        else r.status = 1'b1;
      end
      vwf_pkg::FUNC_DRAW: r = blit_glyph(code, x);
      vwf_pkg::FUNC_READ_TILE: begin
        if (addr < TILE_BYTES) r.read_data = tile_shadow[addr];
        else r.status = 1'b1;
      end
      default: begin
        if (addr < TILE_BYTES) tile_shadow[addr] = data;
        else r.status = 1'b1;
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input blit_result_t want,
      input blit_result_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t: %s: expected next_x=%0d read_data=%02h status=%0d, got next_x=%0d read_data=%02h status=%0d",
               $time, what, want.next_x, want.read_data, want.status,
               got.next_x, got.read_data, got.status);
  endtask

  always @(posedge clk) begin
    blit_result_t got, want;
    if (rst) begin
      color_mode = 1'b0;
      line_base = '0;
      expected_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[10:0], m_tdata[18:11], m_tuser};
        if (expected_q.size() == 0) begin
          flag_mismatch("output transaction with nothing pending", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.next_x !== want.next_x || got.read_data !== want.read_data ||
              got.status !== want.status)
            flag_mismatch("result mismatch", want, got);
        end
      end
      if (cfg_we) begin
        case (vwf_pkg::reg_index_t'(cfg_index))
          vwf_pkg::REG_COLOR_MODE: color_mode = cfg_data[0];
          default:                 line_base = cfg_data;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_q.push_back(apply_item(vwf_pkg::func_t'(s_tuser), s_tdata[7:0], s_tdata[17:8],
                                        s_tdata[29:18], s_tdata[37:30]));
    end
    outstanding <= expected_q.size();
    mismatches <= err_cnt;
  end

endmodule

>>> tb/vwf_glyph_blitter_tb.sv
// Top of the glyph blitter testbench: clock, reset, stimulus, configuration and verdict.
// Depends on vwf_pkg, vwf_glyph_blitter and vwf_glyph_blitter_checker.
`timescale 1ns / 1ps

module vwf_glyph_blitter_tb;

  localparam int FONT_BYTES  = vwf_pkg::GLYPH_COUNT_DEF * vwf_pkg::GLYPH_BYTES;
  localparam int TILE_BYTES  = vwf_pkg::TILE_MEM_BYTES_DEF;
  localparam int ITEM_TARGET = 1800;
  localparam int QUIET_FROM  = 1500;
  localparam int PHASE_ITEMS = 300;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [vwf_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [1:0]                    s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b1;
  logic [vwf_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                          m_tuser;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = 1'b0;
  logic [11:0]                   cfg_data = '0;
  int                            mismatches;
  int                            outstanding;

  bit          font_loaded [FONT_BYTES];
  bit          tile_written [TILE_BYTES];
  logic        cur_color = 1'b0;
  logic [11:0] cur_base = '0;
  bit          src_gaps = 1'b1;
  bit          sink_gaps = 1'b1;
  int          sent = 0;

  always #6 clk = ~clk;

  vwf_glyph_blitter u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  vwf_glyph_blitter_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  task automatic send_item(input vwf_pkg::func_t op, input logic [7:0] code,
      input logic [9:0] x, input logic [11:0] addr, input logic [7:0] data);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {2'b00, data, addr, x, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    if (op == vwf_pkg::FUNC_LOAD_FONT && addr < FONT_BYTES) font_loaded[addr] = 1'b1;
    if (op == vwf_pkg::FUNC_WRITE_TILE) tile_written[addr] = 1'b1;
  endtask

  task automatic wait_drained(input int settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_config(input logic color, input logic [11:0] base);
    wait_drained(40);
    cfg_we <= 1'b1;
    cfg_index <= vwf_pkg::REG_COLOR_MODE;
    cfg_data <= {11'd0, color};
    @(posedge clk);
    cfg_index <= vwf_pkg::REG_LINE_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_color = color;
    cur_base = base;
  endtask

  function automatic int tile_size();
    return cur_color ? 32 : 16;
  endfunction

  function automatic int draw_origin(input logic [9:0] x);
    return cur_base + x[9:3] * tile_size();
  endfunction

  function automatic bit draw_fits(input logic [9:0] x);
    return draw_origin(x) + 7 * (tile_size() / 8) + tile_size() < TILE_BYTES;
  endfunction

  function automatic bit in_font(input logic [7:0] code);
    return code >= vwf_pkg::CODE_BASE && code - vwf_pkg::CODE_BASE < vwf_pkg::GLYPH_COUNT_DEF;
  endfunction

  // Mostly positions whose tiles fit, kept near the line start to reuse written tiles.
  function automatic logic [9:0] pick_x();
    int         room, top_col;
    logic [6:0] col;
    logic [2:0] sub;
    room = 4095 - int'(cur_base) - 7 * (tile_size() / 8) - tile_size();
    if (room < 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 1023);
    top_col = room / tile_size();
    if (top_col > 127) top_col = 127;
    if (top_col > 11 && $urandom_range(0, 3) != 0) top_col = 11;
    col = $urandom_range(0, top_col);
    sub = $urandom_range(0, 7);
    return {col, sub};
  endfunction

  task automatic load_glyph(input logic [7:0] code, input logic [7:0] width, input bit solid);
    int fbase;
    fbase = (code - vwf_pkg::CODE_BASE) * vwf_pkg::GLYPH_BYTES;
    send_item(vwf_pkg::FUNC_LOAD_FONT, $urandom_range(0, 255), $urandom_range(0, 1023),
              fbase, width);
    for (int k = 1; k < vwf_pkg::GLYPH_BYTES; k++)
      send_item(vwf_pkg::FUNC_LOAD_FONT, $urandom_range(0, 255), $urandom_range(0, 1023),
                fbase + k, solid ? 8'hFF : $urandom_range(0, 255));
  endtask

  task automatic draw_at(input logic [7:0] code, input logic [9:0] x, input bit reload);
    int  fbase, origin, ts;
    bit  missing;
    if (in_font(code)) begin
      fbase = (code - vwf_pkg::CODE_BASE) * vwf_pkg::GLYPH_BYTES;
      missing = reload;
      for (int k = 0; k < vwf_pkg::GLYPH_BYTES; k++)
        if (!font_loaded[fbase + k]) missing = 1'b1;
      if (missing)
        load_glyph(code, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(1, 8), 1'b0);
    end
    if (draw_fits(x)) begin
      ts = tile_size();
      origin = draw_origin(x);
      for (int k = 0; k < 16; k++) begin
        if (!tile_written[origin + (k % 8) * (ts / 8) + (k / 8) * ts])
          send_item(vwf_pkg::FUNC_WRITE_TILE, $urandom_range(0, 255), $urandom_range(0, 1023),
                    origin + (k % 8) * (ts / 8) + (k / 8) * ts, $urandom_range(0, 255));
      end
    end
    send_item(vwf_pkg::FUNC_DRAW, code, x, $urandom_range(0, 4095), $urandom_range(0, 255));
  endtask

  task automatic read_tile(input int addr);
    if (!tile_written[addr])
      send_item(vwf_pkg::FUNC_WRITE_TILE, $urandom_range(0, 255), $urandom_range(0, 1023),
                addr, $urandom_range(0, 255));
    send_item(vwf_pkg::FUNC_READ_TILE, $urandom_range(0, 255), $urandom_range(0, 1023),
              addr, $urandom_range(0, 255));
  endtask

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 6) == 0) return $urandom_range(0, 255);
    return $urandom_range(32, 127);
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      if (sink_gaps && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("vwf_glyph_blitter verification failed");
    $finish;
  end

  initial begin
    int          pick, next_switch, run_len;
    logic [9:0]  x;
    logic [11:0] base;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed cases: width extremes, bits above the width, invalid codes, store bounds.
    write_config(1'b0, 12'd0);
    load_glyph(8'h20, 8'd0, 1'b1);
    load_glyph(8'h7F, 8'd15, 1'b1);
    load_glyph(8'h41, 8'd3, 1'b1);
    load_glyph(8'h21, 8'd8, 1'b0);
    send_item(vwf_pkg::FUNC_WRITE_TILE, 8'h00, 10'd0, 12'd0, 8'hFF);
    send_item(vwf_pkg::FUNC_WRITE_TILE, 8'hFF, 10'd1023, 12'd4095, 8'h00);
    draw_at(8'h20, 10'd5, 1'b0);
    draw_at(8'h7F, 10'd7, 1'b0);
    draw_at(8'h7F, 10'd0, 1'b0);
    draw_at(8'h41, 10'd3, 1'b0);
    draw_at(8'h21, 10'd1023, 1'b0);
    draw_at(8'h00, 10'd0, 1'b0);
    draw_at(8'h1F, 10'd8, 1'b0);
    draw_at(8'h80, 10'd16, 1'b0);
    draw_at(8'hFF, 10'd1023, 1'b0);
    send_item(vwf_pkg::FUNC_LOAD_FONT, 8'hFF, 10'd1023, FONT_BYTES - 1, 8'h5A);
    send_item(vwf_pkg::FUNC_LOAD_FONT, 8'h00, 10'd0, FONT_BYTES, 8'hA5);
    send_item(vwf_pkg::FUNC_LOAD_FONT, 8'h00, 10'd0, 12'd4095, 8'hFF);
    read_tile(0);
    read_tile(4095);
    read_tile(16);
    write_config(1'b1, 12'd4095);
    draw_at(8'h7F, 10'd0, 1'b0);
    write_config(1'b1, 12'd0);
    draw_at(8'h41, 10'd1023, 1'b0);
    draw_at(8'h7F, 10'd9, 1'b0);
    read_tile(36);

    next_switch = 0;
    while (sent < ITEM_TARGET) begin
      if (sent >= next_switch) begin
        pick = $urandom_range(0, 4);
        if (pick == 0) base = 12'd0;
        else if (pick == 1) base = $urandom_range(3800, 4095);
        else base = $urandom_range(0, 1500);
        write_config($urandom_range(0, 1), base);
        src_gaps = $urandom_range(0, 3) != 0;
        sink_gaps = $urandom_range(0, 3) != 0;
        next_switch = sent + PHASE_ITEMS;
      end
      if (sent >= QUIET_FROM) begin
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        x = pick_x();
        draw_at(pick_code(), x, $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 2) == 0)
          read_tile((draw_origin(x) + $urandom_range(0, 2 * tile_size() - 1)) % TILE_BYTES);
      end else if (pick < 60) begin
        x = pick_x();
        run_len = $urandom_range(3, 8);
        for (int k = 0; k < run_len; k++) begin
          draw_at(pick_code(), x, 1'b0);
          x = x + $urandom_range(0, 9);
        end
      end else if (pick < 72) begin
        send_item(vwf_pkg::FUNC_WRITE_TILE, $urandom_range(0, 255), $urandom_range(0, 1023),
                  $urandom_range(0, 4095), $urandom_range(0, 255));
      end else if (pick < 85) begin
        read_tile($urandom_range(0, 4095));
      end else begin
        send_item(vwf_pkg::FUNC_LOAD_FONT, $urandom_range(0, 255), $urandom_range(0, 1023),
                  ($urandom_range(0, 1) == 0) ? $urandom_range(0, FONT_BYTES - 1)
                                              : $urandom_range(0, 4095),
                  $urandom_range(0, 255));
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 20000 && outstanding != 0; k++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("vwf_glyph_blitter verification clean");
    end else begin
      $display("vwf_glyph_blitter verification failed");
    end
    $finish;
  end

endmodule
